// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the window averager RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define AWA_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("awa assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define AWA_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("awa assertion failed");

`endif

// ----- hdl/awa_pkg.sv -----
// Shared constants, types and result record of the ADC window averager.
package awa_pkg;

  localparam int CHANNELS     = 8;
  localparam int WINDOW_LOG2  = 8;
  localparam int WIN_LEN      = 1 << WINDOW_LOG2;
  localparam int CH_W         = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int ADDR_W       = CH_W + WINDOW_LOG2;
  localparam int RING_DEPTH   = CHANNELS * WIN_LEN;
  localparam int CHAN_FIELD_W = 3;
  localparam int SAMPLE_W     = 12;
  localparam int SUM_W        = SAMPLE_W + WINDOW_LOG2;
  localparam int FULL_SCALE   = 4095;
  localparam int MV_REF       = 3300;
  localparam int MV_SHIFT     = 12;
  localparam int MV_W         = 12;
  localparam int MV_PROD_W    = SAMPLE_W + MV_SHIFT;

  typedef logic [SAMPLE_W-1:0]     sample_t;
  typedef logic signed [SAMPLE_W-1:0] offset_t;
  typedef logic [SUM_W-1:0]        sum_t;
  typedef logic [WINDOW_LOG2-1:0]  ptr_t;
  typedef logic [CH_W-1:0]         chan_idx_t;
  typedef logic [ADDR_W-1:0]       ring_addr_t;
  typedef logic [CHAN_FIELD_W-1:0] chan_field_t;
  typedef logic [MV_W-1:0]         mv_t;
  typedef logic [MV_PROD_W-1:0]    mv_prod_t;

  // Averaged result passed from the averaged stage to the output stage
  typedef struct packed {
    chan_field_t channel;
    sample_t     average;
  } awa_result_t;

endpackage

// ----- hdl/awa_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module awa_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 2048
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic                                        re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, held while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/awa_clamp.sv -----
// Calibration offset and clamp of one raw converter reading.
module awa_clamp import awa_pkg::*; (
  input  sample_t raw_sample,
  input  offset_t offset,
  output sample_t corrected
);

  logic signed [SAMPLE_W+1:0] biased;

  // Add offset in a width that holds every sum
  assign biased = $signed({2'b00, raw_sample}) + $signed({{2{offset[SAMPLE_W-1]}}, offset});

  // Pin raw zero and raw full scale, clamp the rest to the code range
  always_comb begin
    if ((raw_sample == '0) || (biased < 0)) begin
      corrected = '0;
    end else if ((raw_sample == SAMPLE_W'(FULL_SCALE)) || (biased > FULL_SCALE)) begin
      corrected = SAMPLE_W'(FULL_SCALE);
    end else begin
      corrected = biased[SAMPLE_W-1:0];
    end
  end

endmodule

// ----- hdl/awa_out_stage.sv -----
// Output register stage: millivolt scaling and result hand-off.
module awa_out_stage import awa_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        res_valid,
  input  awa_result_t res,
  output logic        res_ready,
  output logic        out_valid,
  input  logic        out_stall,
  output chan_field_t out_channel,
  output sample_t     average_code,
  output mv_t         millivolts
);

  mv_prod_t product;

  // Scale to millivolts of the reference
  assign product   = mv_prod_t'(res.average) * mv_prod_t'(MV_REF);
  assign res_ready = !out_valid || !out_stall;

  // Control: take a new result whenever the register is free or draining
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  // Payload: hold while stalled
  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_channel  <= res.channel;
      average_code <= res.average;
      millivolts   <= product[MV_PROD_W-1:MV_SHIFT];
    end
  end

endmodule

// ----- hdl/adc_window_averager.sv -----
// An accepted sample goes to the accumulate stage register, then to the averaged stage and output registers.
// Throughput: one sample per cycle while in_stall is low; the ring RAM takes one read and one write a cycle.
// Running sums are read and written back in the accumulate stage, ready for the next sample.
// Reset clears pipeline valids, pointers, wrap flags, sums and the calibration offset.
// The ring RAM is not swept: a channel's wrap flag masks its unwritten slots as zero.
`include "assert_macros.svh"

module adc_window_averager import awa_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  offset_t     cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  chan_field_t channel,
  input  sample_t     raw_sample,
  output logic        out_valid,
  input  logic        out_stall,
  output chan_field_t out_channel,
  output sample_t     average_code,
  output mv_t         millivolts
);

  offset_t     calibration_offset;
  sample_t     corrected;
  logic        in_accept;
  logic        in_range;
  chan_idx_t   in_idx;

  ptr_t        write_pointers [CHANNELS];
  logic [CHANNELS-1:0] wrapped;
  sum_t        window_sums [CHANNELS];

  // Accumulate stage
  logic        s1_valid;
  chan_field_t s1_chan;
  logic        s1_in_range;
  chan_idx_t   s1_idx;
  ring_addr_t  s1_addr;
  sample_t     s1_val;
  logic        s1_old_valid;
  sample_t     ring_rdata;
  sample_t     old_val;
  sum_t        new_sum;
  logic        s1_adv;
  logic        s1_ready;

  // Averaged stage
  logic        s2_valid;
  awa_result_t s2_res;
  logic        s2_ready;
  logic        out_ready;

  // Millivolt figure recomputed from the output code
  mv_t         mv_check;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      calibration_offset <= '0;
    end else if (cfg_we) begin
      calibration_offset <= cfg_wdata;
    end
  end

  awa_clamp u_clamp (
    .raw_sample (raw_sample),
    .offset     (calibration_offset),
    .corrected  (corrected)
  );

  // Handshake chain: each stage advances when the next one is free or draining
  assign s2_ready  = !s2_valid || out_ready;
  assign s1_ready  = !s1_valid || s2_ready;
  assign in_stall  = !s1_ready;
  assign in_accept = in_valid && s1_ready;
  assign s1_adv    = s1_valid && s2_ready;

  assign in_range = (32'(channel) < CHANNELS);
  assign in_idx   = CH_W'(channel);

  // Advance write pointer and note a wrap of the channel's ring
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        write_pointers[i] <= '0;
      end
      wrapped <= '0;
    end else if (in_accept && in_range) begin
      write_pointers[in_idx] <= write_pointers[in_idx] + 1'b1;
      if (write_pointers[in_idx] == '1) begin
        wrapped[in_idx] <= 1'b1;
      end
    end
  end

  // Ring store: read the oldest slot on accept, write the new sample on advance
  awa_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (s1_adv && s1_in_range),
    .waddr (s1_addr),
    .wdata (s1_val),
    .re    (in_accept && in_range),
    .raddr ({in_idx, write_pointers[in_idx]}),
    .rdata (ring_rdata)
  );

  // Load the accumulate stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_chan      <= channel;
      s1_in_range  <= in_range;
      s1_idx       <= in_idx;
      s1_addr      <= {in_idx, write_pointers[in_idx]};
      s1_val       <= corrected;
      s1_old_valid <= wrapped[in_idx];
    end
  end

  // Drop the outgoing sample from the sum and add the new one
  assign old_val = s1_old_valid ? ring_rdata : '0;
  assign new_sum = window_sums[s1_idx] - sum_t'(old_val) + sum_t'(s1_val);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        window_sums[i] <= '0;
      end
    end else if (s1_adv && s1_in_range) begin
      window_sums[s1_idx] <= new_sum;
    end
  end

  // Averaged stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_res.channel <= s1_chan;
      s2_res.average <= s1_in_range ? new_sum[SUM_W-1:WINDOW_LOG2] : '0;
    end
  end

  awa_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .res_valid    (s2_valid),
    .res          (s2_res),
    .res_ready    (out_ready),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_channel  (out_channel),
    .average_code (average_code),
    .millivolts   (millivolts)
  );

  // Checks
  assign mv_check = MV_W'((MV_PROD_W'(average_code) * MV_PROD_W'(MV_REF)) >> MV_SHIFT);

  `AWA_ASSERT_NEXT(a_accept_fills_stage, in_accept, s1_valid)
  `AWA_ASSERT_IMPL(a_mv_matches_average, out_valid, millivolts == mv_check)
  `AWA_ASSERT_IMPL(a_empty_after_reset, $fell(rst), !s1_valid && !s2_valid && !out_valid)

endmodule
